[rtl/core/oas_pkg.sv]
`timescale 1ns / 1ps

package oas_pkg;

    localparam int PLAN_DEPTH = 8;
    localparam int LEN_W      = 4;
    localparam int POS_W      = 3;
    localparam int DIST_W     = 9;
    localparam int SPEED_W    = 16;
    localparam int MS_W       = 9;

    localparam logic [2:0] TRIES_PER_SIDE = 3'd3;
    localparam logic [2:0] UTURN_PULSES   = 3'd6;

    localparam logic [MS_W-1:0] MS_BACKUP_BOTH = 9'd500;
    localparam logic [MS_W-1:0] MS_ESCAPE_BOTH = 9'd400;
    localparam logic [MS_W-1:0] MS_SIDE_TURN   = 9'd300;
    localparam logic [MS_W-1:0] MS_BACKUP      = 9'd200;
    localparam logic [MS_W-1:0] MS_SETTLE      = 9'd60;
    localparam logic [MS_W-1:0] MS_UTURN       = 9'd350;

    localparam logic [1:0] SCAN_GO_RIGHT = 2'd1;
    localparam logic [1:0] SCAN_TRAPPED  = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_THRESHOLD = 1'b0;
    localparam logic CFG_SPEED     = 1'b1;

    typedef enum logic [2:0] {
        CMD_FACE   = 3'd0,
        CMD_STOP   = 3'd1,
        CMD_FWD    = 3'd2,
        CMD_BACK   = 3'd3,
        CMD_LEFT   = 3'd4,
        CMD_RIGHT  = 3'd5,
        CMD_WAIT   = 3'd6,
        CMD_CENTER = 3'd7
    } t_cmd;

    typedef enum logic [1:0] {
        FACE_CALM = 2'd0,
        FACE_WARN = 2'd1,
        FACE_GLUM = 2'd2
    } t_face;

    typedef enum logic [1:0] {
        PH_DRIVE = 2'd0,
        PH_TRIAL = 2'd2,
        PH_UTURN = 2'd3
    } t_phase;

    typedef struct packed {
        t_phase     phase;
        logic       turn_right;
        logic [2:0] try_count;
        logic       side_switches;
    } t_ctl;

    typedef struct packed {
        t_cmd            cmd;
        logic [MS_W-1:0] ms;
        t_face           face;
    } t_entry;

    function automatic t_entry mk_cmd(input t_cmd c);
        t_entry e;
        e.cmd  = c;
        e.ms   = '0;
        e.face = FACE_CALM;
        return e;
    endfunction

    function automatic t_entry mk_wait(input logic [MS_W-1:0] ms);
        t_entry e;
        e.cmd  = CMD_WAIT;
        e.ms   = ms;
        e.face = FACE_CALM;
        return e;
    endfunction

    function automatic t_entry mk_face(input t_face f);
        t_entry e;
        e.cmd  = CMD_FACE;
        e.ms   = '0;
        e.face = f;
        return e;
    endfunction

    function automatic logic is_move(input t_cmd c);
        return (c == CMD_FWD) || (c == CMD_BACK) || (c == CMD_LEFT) || (c == CMD_RIGHT);
    endfunction

endpackage

[rtl/core/oas_plan.sv]
`timescale 1ns / 1ps

// Builds the whole command list of one tick and the control state that follows it.
module oas_plan import oas_pkg::*; (
    input  t_ctl                    i_state,
    input  logic [DIST_W-1:0]       i_threshold,
    input  logic                    i_ir_left_clear,
    input  logic                    i_ir_right_clear,
    input  logic [DIST_W-1:0]       i_front_distance,
    input  logic [1:0]              i_scan_path,
    input  logic [DIST_W-1:0]       i_recheck_distance,
    output t_ctl                    o_next,
    output t_entry [PLAN_DEPTH-1:0] o_plan,
    output logic [LEN_W-1:0]        o_len
);

    logic [2:0] tn;
    logic       recheck_far;

    assign tn          = i_state.try_count + 3'd1;
    assign recheck_far = i_recheck_distance > i_threshold;

    always_comb begin
        o_plan = '0;
        o_len  = '0;
        o_next = i_state;
        if (!i_ir_left_clear || !i_ir_right_clear) begin
            o_plan[0] = mk_face(FACE_WARN);
            o_plan[1] = mk_cmd(CMD_STOP);
            if (!i_ir_left_clear && !i_ir_right_clear) begin
                o_plan[2] = mk_cmd(CMD_BACK);
                o_plan[3] = mk_wait(MS_BACKUP_BOTH);
                o_plan[4] = mk_cmd(CMD_LEFT);
                o_plan[5] = mk_wait(MS_ESCAPE_BOTH);
                o_plan[6] = mk_cmd(CMD_CENTER);
                o_plan[7] = mk_cmd(CMD_FWD);
                o_len     = 4'd8;
            end else begin
                o_plan[2] = mk_cmd(i_ir_left_clear ? CMD_LEFT : CMD_RIGHT);
                o_plan[3] = mk_wait(MS_SIDE_TURN);
                o_plan[4] = mk_cmd(CMD_CENTER);
                o_plan[5] = mk_cmd(CMD_FWD);
                o_len     = 4'd6;
            end
            o_next.phase     = PH_DRIVE;
            o_next.try_count = '0;
        end else if (i_front_distance == '0 || i_front_distance > i_threshold) begin
            o_plan[0]    = mk_cmd(CMD_FWD);
            o_plan[1]    = mk_cmd(CMD_CENTER);
            o_plan[2]    = mk_face(FACE_CALM);
            o_len        = 4'd3;
            o_next.phase = PH_DRIVE;
        end else begin
            case (i_state.phase)
                PH_DRIVE: begin
                    o_plan[0] = mk_face(FACE_WARN);
                    o_plan[1] = mk_cmd(CMD_STOP);
                    o_plan[2] = mk_cmd(CMD_BACK);
                    o_plan[3] = mk_wait(MS_BACKUP);
                    o_plan[4] = mk_cmd(CMD_STOP);
                    if (i_scan_path == SCAN_TRAPPED) begin
                        // The try count is kept here, so a leftover count shortens the U-turn.
                        o_plan[5]    = mk_face(FACE_GLUM);
                        o_len        = 4'd6;
                        o_next.phase = PH_UTURN;
                    end else begin
                        o_len                = 4'd5;
                        o_next.turn_right    = (i_scan_path == SCAN_GO_RIGHT);
                        o_next.try_count     = '0;
                        o_next.side_switches = 1'b0;
                        o_next.phase         = PH_TRIAL;
                    end
                end
                PH_TRIAL: begin
                    o_plan[0] = mk_cmd(i_state.turn_right ? CMD_RIGHT : CMD_LEFT);
                    o_plan[1] = mk_wait(MS_SIDE_TURN);
                    o_plan[2] = mk_cmd(CMD_STOP);
                    o_plan[3] = mk_wait(MS_SETTLE);
                    o_len     = 4'd4;
                    o_next.try_count = tn;
                    if (recheck_far) begin
                        o_plan[4]    = mk_cmd(CMD_CENTER);
                        o_len        = 4'd5;
                        o_next.phase = PH_DRIVE;
                    end else if (tn >= TRIES_PER_SIDE) begin
                        o_next.turn_right = ~i_state.turn_right;
                        o_next.try_count  = '0;
                        if (i_state.side_switches) begin
                            o_next.side_switches = 1'b0;
                            o_next.phase         = PH_UTURN;
                        end else begin
                            o_next.side_switches = 1'b1;
                        end
                    end
                end
                PH_UTURN: begin
                    o_plan[0] = mk_face(FACE_GLUM);
                    o_plan[1] = mk_cmd(CMD_LEFT);
                    o_plan[2] = mk_wait(MS_UTURN);
                    o_plan[3] = mk_cmd(CMD_STOP);
                    o_plan[4] = mk_wait(MS_SETTLE);
                    o_len     = 4'd5;
                    o_next.try_count = tn;
                    if (tn >= UTURN_PULSES || recheck_far) begin
                        o_plan[5]        = mk_cmd(CMD_CENTER);
                        o_len            = 4'd6;
                        o_next.phase     = PH_DRIVE;
                        o_next.try_count = '0;
                    end
                end
                default: begin
                    // The unused phase code emits nothing and changes nothing.
                    o_len = '0;
                end
            endcase
        end
    end

endmodule

[rtl/core/obstacle_avoidance_sequencer_core.sv]
`timescale 1ns / 1ps

// Channel   Direction  Handshake                  Payload
// ------    ---------  -------------------------  -------------------------------------------
// input     in         i_in_valid / o_in_ready    IR flags, front and recheck distance, scan
// result    out        o_out_valid / i_out_ready  command, speed, wait, face, last flag
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// An input transaction is decoded in the cycle it is accepted: the whole command list (up to
// eight entries) and the next control state are captured at that edge. The list then drains
// from the plan buffer into the output register at one result per cycle while the output is
// not stalled; a tick has three to eight commands. The plan buffer's drain port sets the rate.
// A new input transaction is taken in the same cycle the last entry moves to the output
// register. Synchronous active-low reset clears state, speed and valids; threshold is 30.
// A stalled output holds its result and stops the drain; configuration is always ready.
module obstacle_avoidance_sequencer_core import oas_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_ir_left_clear,
    input  logic               i_ir_right_clear,
    input  logic [DIST_W-1:0]  i_front_distance,
    input  logic [1:0]         i_scan_path,
    input  logic [DIST_W-1:0]  i_recheck_distance,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [2:0]         o_command,
    output logic [SPEED_W-1:0] o_move_speed,
    output logic [MS_W-1:0]    o_wait_ms,
    output logic [1:0]         o_face_code,
    output logic               o_last_command,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [15:0]        i_cfg_data
);

    // Configuration registers.
    logic [DIST_W-1:0]  r_threshold;
    logic [SPEED_W-1:0] r_drive_speed;

    // Control state carried from tick to tick.
    t_ctl r_state;
    t_ctl n_state;

    // Plan buffer: the decoded command list of the tick being drained.
    t_entry [PLAN_DEPTH-1:0] r_plan;
    t_entry [PLAN_DEPTH-1:0] n_plan;
    logic [LEN_W-1:0]        r_len;
    logic [LEN_W-1:0]        n_len;
    logic [POS_W-1:0]        r_pos;
    logic                    r_busy;

    // Output register.
    logic               r_out_valid;
    t_cmd               r_cmd;
    logic [SPEED_W-1:0] r_speed;
    logic [MS_W-1:0]    r_ms;
    t_face              r_face;
    logic               r_last;

    logic   s_pop;
    logic   s_last;
    logic   s_in_acc;
    t_entry s_head;

    oas_plan u_plan (
        .i_state            (r_state),
        .i_threshold        (r_threshold),
        .i_ir_left_clear    (i_ir_left_clear),
        .i_ir_right_clear   (i_ir_right_clear),
        .i_front_distance   (i_front_distance),
        .i_scan_path        (i_scan_path),
        .i_recheck_distance (i_recheck_distance),
        .o_next             (n_state),
        .o_plan             (n_plan),
        .o_len              (n_len)
    );

    assign s_head   = r_plan[r_pos];
    assign s_last   = ({1'b0, r_pos} == (r_len - 4'd1));
    assign s_pop    = r_busy && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_busy || (s_pop && s_last);
    assign s_in_acc = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold   <= 9'd30;
            r_drive_speed <= '0;
            r_state       <= '{phase: PH_DRIVE, turn_right: 1'b0, try_count: 3'd0,
                               side_switches: 1'b0};
            r_busy        <= 1'b0;
            r_pos         <= '0;
            r_len         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_THRESHOLD: r_threshold   <= i_cfg_data[DIST_W-1:0];
                    CFG_SPEED:     r_drive_speed <= i_cfg_data[SPEED_W-1:0];
                    default: ;
                endcase
            end

            // Drain one plan entry into the output register when it is free.
            if (s_pop) begin
                r_out_valid <= 1'b1;
                r_cmd       <= s_head.cmd;
                r_speed     <= is_move(s_head.cmd) ? r_drive_speed : '0;
                r_ms        <= s_head.ms;
                r_face      <= s_head.face;
                r_last      <= s_last;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            // A new tick overwrites the buffer once its last entry has left; otherwise the
            // drain position steps forward with each entry that moves out.
            if (s_in_acc) begin
                r_state <= n_state;
                r_plan  <= n_plan;
                r_len   <= n_len;
                r_pos   <= '0;
                r_busy  <= (n_len != '0);
            end else if (s_pop) begin
                r_pos <= r_pos + 3'd1;
                if (s_last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_command      = r_cmd;
    assign o_move_speed   = r_speed;
    assign o_wait_ms      = r_ms;
    assign o_face_code    = r_face;
    assign o_last_command = r_last;

    // While the buffer is busy, the drain position stays inside the captured list.
    a_pos_in_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_len != '0) && ({1'b0, r_pos} < r_len))
        else $error("plan position outside the captured list");

    // The pulse counter never reaches the U-turn limit between ticks.
    a_try_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.try_count < UTURN_PULSES)
        else $error("try count out of range");

    // Non-move results carry no speed.
    a_speed_only_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !is_move(r_cmd)) |-> (r_speed == '0))
        else $error("speed on a non-move command");

    // Only wait commands carry a hold time.
    a_ms_only_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_cmd != CMD_WAIT)) |-> (r_ms == '0))
        else $error("hold time on a non-wait command");

    // A new tick is never taken while earlier entries of the buffer are still pending.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_in_acc && r_busy) |-> (s_pop && s_last))
        else $error("plan buffer overwritten before drained");

endmodule
